// ===== design/global_ssim_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Global SSIM accumulator assertion macros
// Shared property wrappers, clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_SSIM_ACCUMULATOR_ASSERT_SVH
`define GLOBAL_SSIM_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define GSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Types, operand codes and the finishing microprogram of the SSIM accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int NUM_REGS   = 10;
    localparam int PC_W       = 5;
    localparam int Q_W        = 17;
    localparam int DIV_SHIFT  = 16;
    localparam int DIV_STEPS  = 17;

    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    // operand codes: scratch registers, then constants
    typedef logic [3:0] t_src;
    localparam t_src SRC_R0      = 4'd0;
    localparam t_src SRC_R1      = 4'd1;
    localparam t_src SRC_R2      = 4'd2;
    localparam t_src SRC_R3      = 4'd3;
    localparam t_src SRC_R4      = 4'd4;
    localparam t_src SRC_R5      = 4'd5;
    localparam t_src SRC_R6      = 4'd6;
    localparam t_src SRC_R7      = 4'd7;
    localparam t_src SRC_R8      = 4'd8;
    localparam t_src SRC_R9      = 4'd9;
    localparam t_src SRC_K1      = 4'd10;
    localparam t_src SRC_K65025  = 4'd11;
    localparam t_src SRC_K585225 = 4'd12;
    localparam t_src SRC_K20000  = 4'd13;
    localparam t_src SRC_K10000  = 4'd14;
    localparam t_src SRC_K131072 = 4'd15;

    localparam logic [19:0] K_ONE    = 20'd1;
    localparam logic [19:0] K_C1     = 20'd65025;
    localparam logic [19:0] K_C2     = 20'd585225;
    localparam logic [19:0] K_TWO_E4 = 20'd20000;
    localparam logic [19:0] K_ONE_E4 = 20'd10000;
    localparam logic [19:0] K_Q17    = 20'd131072;

    // accumulator snapshot selects
    typedef logic [2:0] t_ld;
    localparam t_ld LD_N     = 3'd0;
    localparam t_ld LD_SX    = 3'd1;
    localparam t_ld LD_SY    = 3'd2;
    localparam t_ld LD_SXY   = 3'd3;
    localparam t_ld LD_SQSUM = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ABSD,
        OP_MUL,
        OP_DIV,
        OP_CHKQ,
        OP_CHKZ
    } t_op;

    typedef struct packed {
        t_op  op;
        t_src dst;
        t_src src_a;
        t_src src_b;
    } t_uop;

    typedef struct packed {
        logic acc_en;
        logic acc_clear;
        logic load_en;
        t_ld  load_sel;
        logic rd_en;
        t_src rd_a;
        t_src rd_b;
        logic exec;
        logic step;
        logic wr_prod;
        t_op  op;
        t_src dst;
        logic out_load;
        logic out_zero;
        logic out_few;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic lt;
        logic a_zero;
        logic mul_done;
        logic div_done;
    } t_status;

    localparam logic [PC_W-1:0] PROG_LAST = 5'd28;

    // Finishing program: R0..R4 hold N, Sx, Sy, Sxy, Sxx+Syy on entry.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_CHKZ, SRC_R0, SRC_R0, SRC_R0};
        case (pc)
            5'd0:  u = '{OP_MUL,  SRC_R5, SRC_R1, SRC_R2};      // SxSy
            5'd1:  u = '{OP_MUL,  SRC_R6, SRC_R1, SRC_R1};
            5'd2:  u = '{OP_MUL,  SRC_R7, SRC_R2, SRC_R2};
            5'd3:  u = '{OP_ADD,  SRC_R6, SRC_R6, SRC_R7};      // Sx^2+Sy^2
            5'd4:  u = '{OP_MUL,  SRC_R7, SRC_R0, SRC_R0};
            5'd5:  u = '{OP_MUL,  SRC_R7, SRC_R7, SRC_K65025};  // c1 term
            5'd6:  u = '{OP_MUL,  SRC_R8, SRC_R5, SRC_K20000};  // pm
            5'd7:  u = '{OP_ADD,  SRC_R5, SRC_R8, SRC_R7};      // A
            5'd8:  u = '{OP_MUL,  SRC_R6, SRC_R6, SRC_K10000};  // qm
            5'd9:  u = '{OP_ADD,  SRC_R7, SRC_R6, SRC_R7};      // B
            5'd10: u = '{OP_ABSD, SRC_R9, SRC_R0, SRC_K1};      // N-1
            5'd11: u = '{OP_MUL,  SRC_R9, SRC_R0, SRC_R9};
            5'd12: u = '{OP_MUL,  SRC_R9, SRC_R9, SRC_K585225}; // c2 term
            5'd13: u = '{OP_MUL,  SRC_R3, SRC_R0, SRC_R3};
            5'd14: u = '{OP_MUL,  SRC_R3, SRC_R3, SRC_K20000};
            5'd15: u = '{OP_ADD,  SRC_R3, SRC_R3, SRC_R9};      // pp
            5'd16: u = '{OP_MUL,  SRC_R4, SRC_R0, SRC_R4};
            5'd17: u = '{OP_MUL,  SRC_R4, SRC_R4, SRC_K10000};
            5'd18: u = '{OP_ADD,  SRC_R4, SRC_R4, SRC_R9};      // qp
            5'd19: u = '{OP_ABSD, SRC_R4, SRC_R6, SRC_R4};      // Q, lt = qp > qm
            5'd20: u = '{OP_CHKQ, SRC_R0, SRC_R0, SRC_R0};
            5'd21: u = '{OP_MUL,  SRC_R7, SRC_R7, SRC_R4};      // D = B*Q
            5'd22: u = '{OP_CHKZ, SRC_R0, SRC_R7, SRC_R7};
            5'd23: u = '{OP_ABSD, SRC_R3, SRC_R3, SRC_R8};      // |P|, lt = sign
            5'd24: u = '{OP_MUL,  SRC_R5, SRC_R5, SRC_R3};
            5'd25: u = '{OP_MUL,  SRC_R5, SRC_R5, SRC_K131072};
            5'd26: u = '{OP_ADD,  SRC_R5, SRC_R5, SRC_R7};      // num + D
            5'd27: u = '{OP_ADD,  SRC_R7, SRC_R7, SRC_R7};      // 2D
            5'd28: u = '{OP_DIV,  SRC_R0, SRC_R5, SRC_R7};
            default: u = '{OP_CHKZ, SRC_R0, SRC_R0, SRC_R0};
        endcase
        return u;
    endfunction

endpackage

// ===== design/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl
// Sequencer: accumulation, snapshot load, microprogram and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_pixel,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  gsa_pkg::t_status i_status,
    output gsa_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_EXEC   = 6'b001000,
        S_ITER   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [gsa_pkg::PC_W-1:0]  r_pc, n_pc;
    gsa_pkg::t_ld              r_ld, n_ld;
    logic                      r_zero, n_zero;
    logic                      r_few, n_few;
    logic                      r_out_valid, n_out_valid;
    gsa_pkg::t_uop             w_uop;

    assign w_uop       = gsa_pkg::uop_rom(r_pc);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_ld        = r_ld;
        n_zero      = r_zero;
        n_few       = r_few;
        n_out_valid = r_out_valid;

        o_cmd          = '0;
        o_cmd.op       = w_uop.op;
        o_cmd.dst      = w_uop.dst;
        o_cmd.rd_a     = w_uop.src_a;
        o_cmd.rd_b     = w_uop.src_b;
        o_cmd.load_sel = r_ld;
        o_cmd.out_zero = r_zero;
        o_cmd.out_few  = r_few;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_last_pixel) begin
                    n_state = S_LOAD;
                    n_ld    = gsa_pkg::LD_N;
                    n_zero  = 1'b0;
                    n_few   = 1'b0;
                end
            end
            S_LOAD: begin
                if (r_ld == gsa_pkg::LD_N && i_status.few) begin
                    n_few   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.load_en = 1'b1;
                    if (r_ld == gsa_pkg::LD_SQSUM) begin
                        n_pc    = '0;
                        n_state = S_FETCH;
                    end else begin
                        n_ld = r_ld + 3'd1;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                case (w_uop.op)
                    gsa_pkg::OP_ADD, gsa_pkg::OP_ABSD: begin
                        o_cmd.exec = 1'b1;
                        n_pc       = r_pc + 5'd1;
                        n_state    = S_FETCH;
                    end
                    gsa_pkg::OP_MUL, gsa_pkg::OP_DIV: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_ITER;
                    end
                    gsa_pkg::OP_CHKQ: begin
                        if (!i_status.lt) begin
                            n_zero  = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            n_pc    = r_pc + 5'd1;
                            n_state = S_FETCH;
                        end
                    end
                    gsa_pkg::OP_CHKZ: begin
                        if (i_status.a_zero) begin
                            n_zero  = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            n_pc    = r_pc + 5'd1;
                            n_state = S_FETCH;
                        end
                    end
                    default: begin
                        n_zero  = 1'b1;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_ITER: begin
                if (w_uop.op == gsa_pkg::OP_MUL) begin
                    if (i_status.mul_done) begin
                        o_cmd.wr_prod = 1'b1;
                        n_pc          = r_pc + 5'd1;
                        n_state       = S_FETCH;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    if (i_status.div_done) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.acc_clear = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_ld        <= gsa_pkg::LD_N;
            r_zero      <= 1'b0;
            r_few       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_ld        <= n_ld;
            r_zero      <= n_zero;
            r_few       <= n_few;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/gsa_datapath.sv =====
// ----------------------------------------------------------------------------
// gsa_datapath
// Pixel accumulators, scratch register file, shift-add multiplier,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsa_datapath #(
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_pixel_x,
    input  logic [7:0]          i_pixel_y,
    input  gsa_pkg::t_cmd       i_cmd,
    output gsa_pkg::t_status    o_status,
    output logic signed [17:0]  o_ssim_q16,
    output logic [16:0]         o_distance_q16,
    output logic                o_too_few
);

    localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
    localparam int SX_W  = MAX_PIXELS_LOG2 + 8;
    localparam int SQ_W  = MAX_PIXELS_LOG2 + 16;
    // covers 2^17 * A * |P| + B*Q with margin
    localparam int DW    = 4 * MAX_PIXELS_LOG2 + 84;
    localparam int Q_W   = gsa_pkg::Q_W;

    logic [CNT_W-1:0] r_count;
    logic [SX_W-1:0]  r_sum_x, r_sum_y;
    logic [SQ_W-1:0]  r_sum_xx, r_sum_yy, r_sum_xy;
    logic [15:0]      w_xx, w_yy, w_xy;

    logic [DW-1:0]    r_mem [gsa_pkg::NUM_REGS];
    logic [DW-1:0]    r_rd_a, r_rd_b;
    gsa_pkg::t_src    r_src_a, r_src_b;
    logic [DW-1:0]    w_opa, w_opb, w_load, w_alu;
    logic             w_lt;
    logic             r_lt;

    logic [DW-1:0]    r_mcand, r_mplier, r_prod;
    logic [DW-1:0]    r_rem, r_div;
    logic [Q_W-1:0]   r_q;
    logic [4:0]       r_cnt;
    logic             w_ge;

    logic [Q_W-1:0]   w_mag;
    logic signed [17:0] r_ssim;
    logic [16:0]      r_dist;
    logic             r_few;

    function automatic logic [DW-1:0] const_val(input gsa_pkg::t_src s);
        logic [DW-1:0] v;
        v = '0;
        case (s)
            gsa_pkg::SRC_K1:      v = DW'(gsa_pkg::K_ONE);
            gsa_pkg::SRC_K65025:  v = DW'(gsa_pkg::K_C1);
            gsa_pkg::SRC_K585225: v = DW'(gsa_pkg::K_C2);
            gsa_pkg::SRC_K20000:  v = DW'(gsa_pkg::K_TWO_E4);
            gsa_pkg::SRC_K10000:  v = DW'(gsa_pkg::K_ONE_E4);
            gsa_pkg::SRC_K131072: v = DW'(gsa_pkg::K_Q17);
            default:              v = '0;
        endcase
        return v;
    endfunction

    assign w_xx = i_pixel_x * i_pixel_x;
    assign w_yy = i_pixel_y * i_pixel_y;
    assign w_xy = i_pixel_x * i_pixel_y;

    // accumulation stops once the count reaches 2^MAX_PIXELS_LOG2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.acc_clear) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_yy <= '0;
            r_sum_xy <= '0;
        end else if (i_cmd.acc_en && !r_count[MAX_PIXELS_LOG2]) begin
            r_count  <= r_count + CNT_W'(1);
            r_sum_x  <= r_sum_x + SX_W'(i_pixel_x);
            r_sum_y  <= r_sum_y + SX_W'(i_pixel_y);
            r_sum_xx <= r_sum_xx + SQ_W'(w_xx);
            r_sum_yy <= r_sum_yy + SQ_W'(w_yy);
            r_sum_xy <= r_sum_xy + SQ_W'(w_xy);
        end
    end

    always_comb begin
        case (i_cmd.load_sel)
            gsa_pkg::LD_N:     w_load = DW'(r_count);
            gsa_pkg::LD_SX:    w_load = DW'(r_sum_x);
            gsa_pkg::LD_SY:    w_load = DW'(r_sum_y);
            gsa_pkg::LD_SXY:   w_load = DW'(r_sum_xy);
            gsa_pkg::LD_SQSUM: w_load = DW'(r_sum_xx) + DW'(r_sum_yy);
            default:           w_load = '0;
        endcase
    end

    assign w_opa = (r_src_a < 4'(gsa_pkg::NUM_REGS)) ? r_rd_a : const_val(r_src_a);
    assign w_opb = (r_src_b < 4'(gsa_pkg::NUM_REGS)) ? r_rd_b : const_val(r_src_b);
    assign w_lt  = (w_opa < w_opb);
    assign w_alu = (i_cmd.op == gsa_pkg::OP_ADD) ? (w_opa + w_opb)
                 : (w_lt ? (w_opb - w_opa) : (w_opa - w_opb));

    // scratch register file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_mem[{1'b0, i_cmd.load_sel}] <= w_load;
        end else if (i_cmd.exec &&
                     (i_cmd.op == gsa_pkg::OP_ADD || i_cmd.op == gsa_pkg::OP_ABSD)) begin
            r_mem[i_cmd.dst] <= w_alu;
        end else if (i_cmd.wr_prod) begin
            r_mem[i_cmd.dst] <= r_prod;
        end
        if (i_cmd.rd_en) begin
            r_rd_a  <= r_mem[i_cmd.rd_a];
            r_rd_b  <= r_mem[i_cmd.rd_b];
            r_src_a <= i_cmd.rd_a;
            r_src_b <= i_cmd.rd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
        end else if (i_cmd.exec && i_cmd.op == gsa_pkg::OP_ABSD) begin
            r_lt <= w_lt;
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (i_cmd.exec && i_cmd.op == gsa_pkg::OP_MUL) begin
            r_mplier <= w_opb;
        end else if (i_cmd.step && i_cmd.op == gsa_pkg::OP_MUL) begin
            r_mplier <= r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.op == gsa_pkg::OP_MUL) begin
            r_mcand <= w_opa;
            r_prod  <= '0;
        end else if (i_cmd.step && i_cmd.op == gsa_pkg::OP_MUL) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand <= r_mcand << 1;
        end
    end

    // restoring divider, one quotient bit per cycle, MSB first
    assign w_ge = (r_rem >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec && i_cmd.op == gsa_pkg::OP_DIV) begin
            r_cnt <= '0;
        end else if (i_cmd.step && i_cmd.op == gsa_pkg::OP_DIV) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.op == gsa_pkg::OP_DIV) begin
            r_rem <= w_opa;
            r_div <= w_opb << gsa_pkg::DIV_SHIFT;
            r_q   <= '0;
        end else if (i_cmd.step && i_cmd.op == gsa_pkg::OP_DIV) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_q   <= {r_q[Q_W-2:0], w_ge};
            r_div <= r_div >> 1;
        end
    end

    assign w_mag = (r_q > gsa_pkg::Q_ONE) ? gsa_pkg::Q_ONE : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_few <= i_cmd.out_few;
            if (i_cmd.out_few || i_cmd.out_zero) begin
                r_ssim <= '0;
                r_dist <= gsa_pkg::Q_ONE;
            end else if (r_lt) begin
                r_ssim <= 18'sd0 - $signed({1'b0, w_mag});
                r_dist <= gsa_pkg::Q_ONE;
            end else begin
                r_ssim <= $signed({1'b0, w_mag});
                r_dist <= gsa_pkg::Q_ONE - w_mag;
            end
        end
    end

    assign o_ssim_q16     = r_ssim;
    assign o_distance_q16 = r_dist;
    assign o_too_few      = r_few;

    assign o_status.few      = (r_count < CNT_W'(2));
    assign o_status.lt       = r_lt;
    assign o_status.a_zero   = (w_opa == '0);
    assign o_status.mul_done = (r_mplier == '0);
    assign o_status.div_done = (r_cnt == 5'(gsa_pkg::DIV_STEPS));

endmodule

`default_nettype wire

// ===== design/global_ssim_accumulator.sv =====
// Global SSIM accumulator. Pixel pairs are taken one per cycle while the block
// accumulates; a pair with last_pixel set stalls the input until the result is
// computed and handed to the output register. The finishing computation runs
// on one shift-add multiplier (one multiplier bit per cycle) and a restoring
// divider. With fewer than two pairs the finishing program is skipped and
// o_too_few is set. A pending result does not block accumulation of the next
// image.
// ----------------------------------------------------------------------------
// global_ssim_accumulator
// Top level: controller plus datapath, valid/ready on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module global_ssim_accumulator #(
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic               i_last_pixel,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_ssim_q16,
    output logic [16:0]        o_distance_q16,
    output logic               o_too_few
);

    gsa_pkg::t_cmd    w_cmd;
    gsa_pkg::t_status w_status;

    gsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_pixel (i_last_pixel),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    gsa_datapath #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_ssim_q16     (o_ssim_q16),
        .o_distance_q16 (o_distance_q16),
        .o_too_few      (o_too_few)
    );

endmodule

`default_nettype wire

// ===== design/gsa_checker.sv =====
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks on the SSIM accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "global_ssim_accumulator_assert.svh"

module gsa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               i_last_pixel,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic signed [17:0] o_ssim_q16,
    input  logic [16:0]        o_distance_q16,
    input  logic               o_too_few
);

    `GSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ssim_q16) && $stable(o_distance_q16) && $stable(o_too_few), "result changed while stalled")

    `GSA_ASSERT_NEXT(a_last_stalls, i_in_valid && o_in_ready && i_last_pixel, !o_in_ready, "input not stalled after last pixel")

    `GSA_ASSERT_NOW(a_few_zero, o_out_valid && o_too_few, o_ssim_q16 == 18'sd0 && o_distance_q16 == 17'd65536, "too_few result not zero")

    `GSA_ASSERT_NOW(a_pos_dist, o_out_valid && !o_ssim_q16[17], o_ssim_q16 <= 18'sd65536 && o_distance_q16 == 17'd65536 - o_ssim_q16[16:0], "distance mismatch")

    `GSA_ASSERT_NOW(a_neg_dist, o_out_valid && o_ssim_q16[17], o_ssim_q16 >= -18'sd65536 && o_distance_q16 == 17'd65536, "negative ssim out of range")

endmodule

bind global_ssim_accumulator gsa_checker u_gsa_checker (.*);

`default_nettype wire
